// File: rtl/tpba_pkg.sv
// Package for the two-pool block allocator.
// Holds handle constants, command/status/register codes, link port and result structs
// and the link reset value. No dependencies.
package tpba_pkg;

  localparam int HANDLE_W  = 8;
  localparam int SIZE_W    = 16;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int SCNT_W    = 8;
  localparam int LCNT_W    = 7;
  localparam int STATUS_W  = 3;

  localparam int TOTAL_DEPTH = 192;

  localparam logic [HANDLE_W-1:0] SMALL_BLOCKS = 8'd128;
  localparam logic [HANDLE_W-1:0] TOTAL_BLOCKS = 8'd192;
  localparam logic [HANDLE_W-1:0] SMALL_BASE   = 8'd0;
  localparam logic [HANDLE_W-1:0] LARGE_BASE   = 8'd128;
  localparam logic [HANDLE_W-1:0] LINK_NULL    = 8'hFF;
  localparam logic [HANDLE_W-1:0] NO_HANDLE    = 8'hFF;
  localparam logic [SCNT_W-1:0]   SMALL_CAP    = 8'd128;
  localparam logic [LCNT_W-1:0]   LARGE_CAP    = 7'd64;

  localparam logic [CFG_W-1:0] SMALL_BYTES_RST = 13'd16;
  localparam logic [CFG_W-1:0] LARGE_BYTES_RST = 13'd32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BYTES = 1'b1;

  localparam logic [STATUS_W-1:0] ST_SMALL_GRANT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LARGE_GRANT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEAP_ALLOC  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SMALL_RET   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LARGE_RET   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HEAP_FREE   = 3'd5;

  typedef struct packed {
    logic                en;
    logic [HANDLE_W-1:0] addr;
    logic [HANDLE_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic                en;
    logic [HANDLE_W-1:0] addr;
  } link_rd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] grant;
    logic [SCNT_W-1:0]   small_used;
    logic [LCNT_W-1:0]   large_used;
  } result_t;

  // Free-list link after reset: next handle of the same pool, null at pool end.
  function automatic logic [HANDLE_W-1:0] init_link(input logic [HANDLE_W-1:0] a);
    logic [HANDLE_W-1:0] nxt;
    nxt = a + 8'd1;
    if (nxt == SMALL_BLOCKS || nxt == TOTAL_BLOCKS) begin
      return LINK_NULL;
    end
    return nxt;
  endfunction

endpackage

// File: rtl/tpba_in_if.sv
// Input channel of the two-pool block allocator: valid/ready plus command payload.
// No dependencies.
interface tpba_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] req_size;
  logic [7:0]  free_handle;

  modport source (output valid, cmd, req_size, free_handle, input ready);
  modport sink   (input valid, cmd, req_size, free_handle, output ready);
endinterface

// File: rtl/tpba_out_if.sv
// Result channel of the two-pool block allocator: valid/ready plus result payload.
// No dependencies.
interface tpba_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] grant_handle;
  logic [7:0] small_used;
  logic [6:0] large_used;

  modport source (output valid, status, grant_handle, small_used, large_used, input ready);
  modport sink   (input valid, status, grant_handle, small_used, large_used, output ready);
endinterface

// File: rtl/tpba_link_mem.sv
// Free-list link memory: one write and one read port, registered read data.
// Per-entry valid bits make unwritten entries read as their reset link.
// Depends on tpba_pkg.
module tpba_link_mem import tpba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  link_wr_t            wr,
  input  link_rd_t            rd,
  output logic [HANDLE_W-1:0] rd_data
);

  logic [HANDLE_W-1:0] mem [TOTAL_DEPTH];
  logic [TOTAL_DEPTH-1:0] vld_r;
  logic [HANDLE_W-1:0] data_r;
  logic [HANDLE_W-1:0] addr_r;
  logic                hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      data_r <= mem[rd.addr];
      addr_r <= rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        hit_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data = hit_r ? data_r : init_link(addr_r);

endmodule

// File: rtl/two_pool_block_allocator.sv
// Two-pool block allocator. Free: result registered from the transfer. Pool
// allocate: link memory read, then head update. One item at a time; 1 free/cycle
// while the output is free, and a pool allocate ends before the next is accepted.
// A result meeting a busy output waits in a holding register, stalling input.
// Sync reset sets heads and block sizes to reset values, clears counts and link
// valid bits. Depends on tpba_pkg, tpba_in_if, tpba_out_if, tpba_link_mem.
module two_pool_block_allocator import tpba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  tpba_in_if.sink              in_ch,
  tpba_out_if.source           out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_HOLD} state_t;

  state_t              st_r, st_nxt;
  logic [HANDLE_W-1:0] small_head_r, small_head_nxt;
  logic [HANDLE_W-1:0] large_head_r, large_head_nxt;
  logic [SCNT_W-1:0]   small_cnt_r, small_cnt_nxt;
  logic [LCNT_W-1:0]   large_cnt_r, large_cnt_nxt;
  logic                sel_large_r, sel_large_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;
  result_t             pend_r, pend_nxt;
  logic [CFG_W-1:0]    small_bytes_r, large_bytes_r;

  link_wr_t            lwr;
  link_rd_t            lrd;
  logic [HANDLE_W-1:0] link_data;

  logic    in_xfer, out_free, res_go, small_fit, large_fit;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_bytes_r <= SMALL_BYTES_RST;
      large_bytes_r <= LARGE_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SMALL_BYTES: small_bytes_r <= cfg_wdata;
        CFG_LARGE_BYTES: large_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tpba_link_mem u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (lwr),
    .rd      (lrd),
    .rd_data (link_data)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign small_fit = ({3'b000, small_bytes_r} > in_ch.req_size) &&
                     (small_cnt_r < SMALL_CAP) && (small_head_r != LINK_NULL);
  assign large_fit = ({3'b000, large_bytes_r} > in_ch.req_size) &&
                     (large_cnt_r < LARGE_CAP) && (large_head_r != LINK_NULL);

  always_comb begin
    st_nxt         = st_r;
    small_head_nxt = small_head_r;
    large_head_nxt = large_head_r;
    small_cnt_nxt  = small_cnt_r;
    large_cnt_nxt  = large_cnt_r;
    sel_large_nxt  = sel_large_r;
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    lwr            = '0;
    lrd            = '0;
    res_go         = 1'b0;
    res            = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.cmd == CMD_FREE) begin
            res_go = 1'b1;
            if (in_ch.free_handle < SMALL_BLOCKS) begin
              lwr            = '{en: 1'b1, addr: in_ch.free_handle, data: small_head_r};
              small_head_nxt = in_ch.free_handle;
              if (small_cnt_r != '0) begin
                small_cnt_nxt = small_cnt_r - 8'd1;
              end
              res.status = ST_SMALL_RET;
            end else if (in_ch.free_handle < TOTAL_BLOCKS) begin
              lwr            = '{en: 1'b1, addr: in_ch.free_handle, data: large_head_r};
              large_head_nxt = in_ch.free_handle;
              if (large_cnt_r != '0) begin
                large_cnt_nxt = large_cnt_r - 7'd1;
              end
              res.status = ST_LARGE_RET;
            end else begin
              res.status = ST_HEAP_FREE;
            end
          end else if (small_fit) begin
            lrd           = '{en: 1'b1, addr: small_head_r};
            sel_large_nxt = 1'b0;
            st_nxt        = S_POP;
          end else if (large_fit) begin
            lrd           = '{en: 1'b1, addr: large_head_r};
            sel_large_nxt = 1'b1;
            st_nxt        = S_POP;
          end else begin
            res_go     = 1'b1;
            res.status = ST_HEAP_ALLOC;
          end
        end
      end
      S_POP: begin
        res_go = 1'b1;
        if (sel_large_r) begin
          large_head_nxt = link_data;
          large_cnt_nxt  = large_cnt_r + 7'd1;
          res.status     = ST_LARGE_GRANT;
        end else begin
          small_head_nxt = link_data;
          small_cnt_nxt  = small_cnt_r + 8'd1;
          res.status     = ST_SMALL_GRANT;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    res.grant      = (st_r == S_POP) ? (sel_large_r ? large_head_r : small_head_r)
                                     : NO_HANDLE;
    res.small_used = small_cnt_nxt;
    res.large_used = large_cnt_nxt;

    if (res_go) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
      end else begin
        pend_nxt = res;
        st_nxt   = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      small_head_r <= SMALL_BASE;
      large_head_r <= LARGE_BASE;
      small_cnt_r  <= '0;
      large_cnt_r  <= '0;
      sel_large_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      small_head_r <= small_head_nxt;
      large_head_r <= large_head_nxt;
      small_cnt_r  <= small_cnt_nxt;
      large_cnt_r  <= large_cnt_nxt;
      sel_large_r  <= sel_large_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.grant_handle = out_r.grant;
  assign out_ch.small_used   = out_r.small_used;
  assign out_ch.large_used   = out_r.large_used;

`ifndef NO_ASSERTIONS
  a_link_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(lwr.en && lrd.en))
    else $error("link memory read and write in the same cycle");

  a_pop_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    lrd.en |=> st_r == S_POP)
    else $error("link read not followed by pop");

  a_hold_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_HOLD |-> out_valid_r)
    else $error("result held while output register empty");

  a_count_caps: assert property (@(posedge clk) disable iff (!rst_n)
    small_cnt_r <= SMALL_CAP && large_cnt_r <= LARGE_CAP)
    else $error("pool use count above capacity");
`endif

endmodule
